>>> rtl/core/lldq_pkg.sv
// ----------------------------------------------------------------------------
// lldq_pkg
// Shared types and constants for the link delay queue.
// ----------------------------------------------------------------------------
`default_nettype none
package lldq_pkg;
   localparam int DgramSlots    = 16;
   localparam int RelSlots      = 16;
   localparam int DgramMaxBytes = 1024;
   localparam int RelMaxBytes   = 1024;
   localparam int TickW = 48;
   localparam int SizeW = 11;
   localparam logic [SizeW-1:0] OffsetMax = 11'd2047;

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0, ACT_POLL = 2'd1, ACT_SEND = 2'd2, ACT_RECV = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_DROPPED = 3'd1, ST_NOT_CONN = 3'd2, ST_TOO_LONG = 3'd3,
      ST_FULL = 3'd4, ST_NONE = 3'd5, ST_ROOM = 3'd6, ST_CONT = 3'd7
   } status_type;

   localparam logic [1:0] REG_LATENCY = 2'd0;
   localparam logic [1:0] REG_DROP    = 2'd1;
   localparam logic [1:0] REG_CONN    = 2'd2;
endpackage
`default_nettype wire

>>> rtl/core/lldq_ram.sv
// ----------------------------------------------------------------------------
// lldq_ram
// Generic simple dual-port RAM (one write port, one read port) with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module lldq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/core/loopback_link_delay_queue.sv
// ----------------------------------------------------------------------------
// loopback_link_delay_queue
// One direction of a two-lane link emulator with delayed delivery.
// ----------------------------------------------------------------------------
// Channel  | Ports                       | Handshake
// request  | req_* , start, busy         | accepted when start && !busy
// response | rsp_* , rsp_strobe          | one cycle, cannot be stalled
// config   | csr_*                       | accepted when csr_valid && csr_ready
//
// Tick, send and receive items pass an accept step, which reads the slot
// memories, and an execute step, which answers and writes back. A poll
// walks the due-tick memory of each lane, one read and one check per slot.
// Reset is synchronous; memories are not cleared, since each slot is
// written before it is read. busy stays high while an item is at work.
// ----------------------------------------------------------------------------
`default_nettype none
module loopback_link_delay_queue #(
   parameter int DgramSlots    = lldq_pkg::DgramSlots,
   parameter int RelSlots      = lldq_pkg::RelSlots,
   parameter int DgramMaxBytes = lldq_pkg::DgramMaxBytes,
   parameter int RelMaxBytes   = lldq_pkg::RelMaxBytes
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_lane,
   input  wire logic [47:0] req_tick_value,
   input  wire logic [15:0] req_length,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_last,
   input  wire logic [15:0] req_buffer_room,
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_data_byte_out,
   output logic             rsp_last_out,
   output logic [10:0]      rsp_message_length,
   output logic [4:0]       rsp_queued_datagrams,
   output logic [4:0]       rsp_queued_reliable,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);
   localparam int TW = lldq_pkg::TickW;
   localparam int SW = lldq_pkg::SizeW;
   localparam int DSW = (DgramSlots > 1) ? $clog2(DgramSlots) : 1;
   localparam int RSW = (RelSlots > 1) ? $clog2(RelSlots) : 1;
   localparam int DBW = (DgramMaxBytes > 1) ? $clog2(DgramMaxBytes) : 1;
   localparam int RBW = (RelMaxBytes > 1) ? $clog2(RelMaxBytes) : 1;
   localparam int DCW = $clog2(DgramSlots + 1);
   localparam int RCW = $clog2(RelSlots + 1);
   localparam int DDEPTH = (DgramSlots > 1) ? DgramSlots : 2;
   localparam int RDEPTH = (RelSlots > 1) ? RelSlots : 2;
   localparam int DBDEPTH = (1 << DSW) * (1 << DBW);
   localparam int RBDEPTH = (1 << RSW) * (1 << RBW);
   localparam logic [DCW-1:0] DSlotsC = DCW'(DgramSlots);
   localparam logic [RCW-1:0] RSlotsC = RCW'(RelSlots);
   localparam logic [SW-1:0]  DMaxC = SW'(DgramMaxBytes);
   localparam logic [SW-1:0]  RMaxC = SW'(RelMaxBytes);

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_PWAIT, S_PCHK, S_DONE} state_type;

   // Configuration.
   logic [15:0] latency_ff, drop_n_ff;
   logic        conn_ff;

   // Control state.
   state_type     state_ff;
   logic [TW-1:0] tick_ff;
   logic [15:0]   loss_ff;
   logic [DSW-1:0] dhead_ff;
   logic [DCW-1:0] dcount_ff, dready_ff;
   logic [RSW-1:0] rhead_ff;
   logic [RCW-1:0] rcount_ff, rready_ff;
   logic [SW-1:0]  woff_ff, slen_ff, roff0_ff, roff1_ff;
   logic [2:0]     verdict_ff;
   logic           slane_ff;
   logic           plane_ff;

   // Latched request.
   logic [1:0]  act_ff;
   logic        lane_ff;
   logic [15:0] len_ff, room_ff;
   logic [7:0]  byte_ff;
   logic        last_ff;

   // Response registers.
   logic          strobe_ff;
   logic [2:0]    status_ff;
   logic [7:0]    dout_ff;
   logic          lout_ff;
   logic [SW-1:0] mlen_ff;

   // Memory ports.
   logic           dmeta_we, rmeta_we, dbyte_we, rbyte_we;
   logic [DSW-1:0] dmeta_wa, dmeta_ra;
   logic [RSW-1:0] rmeta_wa, rmeta_ra;
   logic [TW+SW-1:0] meta_wd, dmeta_rd, rmeta_rd;
   logic [DSW+DBW-1:0] dbyte_wa, dbyte_ra;
   logic [RSW+RBW-1:0] rbyte_wa, rbyte_ra;
   logic [7:0] dbyte_rd, rbyte_rd;

   lldq_ram #(.Width(TW + SW), .Depth(DDEPTH)) u_dmeta (
      .clock, .wr_en(dmeta_we), .wr_addr(dmeta_wa), .wr_data(meta_wd),
      .rd_addr(dmeta_ra), .rd_data(dmeta_rd));
   lldq_ram #(.Width(TW + SW), .Depth(RDEPTH)) u_rmeta (
      .clock, .wr_en(rmeta_we), .wr_addr(rmeta_wa), .wr_data(meta_wd),
      .rd_addr(rmeta_ra), .rd_data(rmeta_rd));
   lldq_ram #(.Width(8), .Depth(DBDEPTH)) u_dbytes (
      .clock, .wr_en(dbyte_we), .wr_addr(dbyte_wa), .wr_data(byte_ff),
      .rd_addr(dbyte_ra), .rd_data(dbyte_rd));
   lldq_ram #(.Width(8), .Depth(RBDEPTH)) u_rbytes (
      .clock, .wr_en(rbyte_we), .wr_addr(rbyte_wa), .wr_data(byte_ff),
      .rd_addr(rbyte_ra), .rd_data(rbyte_rd));

   // Ring positions.
   function automatic logic [DSW-1:0] dwrap(input logic [DCW:0] v);
      logic [DCW:0] s;
      s = DCW'(DgramSlots) + (DCW+1)'(0);
      return (v >= s) ? DSW'(v - s) : DSW'(v);
   endfunction
   function automatic logic [RSW-1:0] rwrap(input logic [RCW:0] v);
      logic [RCW:0] s;
      s = RCW'(RelSlots) + (RCW+1)'(0);
      return (v >= s) ? RSW'(v - s) : RSW'(v);
   endfunction

   logic [DSW-1:0] dtail, dpoll;
   logic [RSW-1:0] rtail, rpoll;
   logic [SW-1:0]  roff_sel;
   assign dtail = dwrap((DCW+1)'(dhead_ff) + (DCW+1)'(dcount_ff));
   assign rtail = rwrap((RCW+1)'(rhead_ff) + (RCW+1)'(rcount_ff));
   assign dpoll = dwrap((DCW+1)'(dhead_ff) + (DCW+1)'(dready_ff));
   assign rpoll = rwrap((RCW+1)'(rhead_ff) + (RCW+1)'(rready_ff));
   assign roff_sel = lane_ff ? roff1_ff : roff0_ff;

   // First-item verdict, evaluated in the execute cycle.
   logic          first;
   logic          v_lane;
   logic [2:0]    v_verdict;
   logic [15:0]   v_loss;
   logic [16:0]   loss_inc;
   logic [SW-1:0] v_len;
   logic          cur_lane;
   logic [2:0]    cur_verdict;
   logic [SW-1:0] cur_len;
   logic          lane_full;

   assign first = (woff_ff == '0);
   assign loss_inc = 17'(loss_ff) + 17'd1;

   always_comb begin
      v_loss = loss_ff;
      v_len  = '0;
      v_lane = lane_ff;
      if (!conn_ff) begin
         v_verdict = lldq_pkg::ST_NOT_CONN;
      end else if (len_ff > 16'(lane_ff ? RMaxC : DMaxC)) begin
         v_verdict = lldq_pkg::ST_TOO_LONG;
      end else if (!lane_ff && drop_n_ff != '0 && loss_inc >= 17'(drop_n_ff)) begin
         v_verdict = lldq_pkg::ST_DROPPED;
         v_loss = '0;
      end else begin
         if (!lane_ff) begin
            v_loss = loss_inc[15:0];
         end
         if (lane_ff ? (rcount_ff >= RSlotsC) : (dcount_ff >= DSlotsC)) begin
            v_verdict = lldq_pkg::ST_FULL;
         end else begin
            v_verdict = lldq_pkg::ST_OK;
            v_len = SW'(len_ff);
         end
      end
      cur_lane    = first ? v_lane : slane_ff;
      cur_verdict = first ? v_verdict : verdict_ff;
      cur_len     = first ? v_len : slen_ff;
   end

   assign lane_full = cur_lane ? (rcount_ff >= RSlotsC) : (dcount_ff >= DSlotsC);

   logic [SW-1:0] woff_next, qsize;
   assign woff_next = (woff_ff < lldq_pkg::OffsetMax) ? woff_ff + 1'b1 : woff_ff;
   assign qsize = (cur_len < woff_next) ? cur_len : woff_next;
   assign meta_wd = {tick_ff + TW'(latency_ff), qsize};

   logic exec_send, store_byte, queue_msg;
   assign exec_send  = (state_ff == S_EXEC) && (act_ff == lldq_pkg::ACT_SEND);
   assign store_byte = exec_send && cur_verdict == lldq_pkg::ST_OK &&
                       woff_ff < cur_len && !lane_full;
   assign queue_msg  = exec_send && last_ff && cur_verdict == lldq_pkg::ST_OK &&
                       !lane_full;

   assign dbyte_we = store_byte && !cur_lane;
   assign rbyte_we = store_byte && cur_lane;
   assign dbyte_wa = {dtail, DBW'(woff_ff)};
   assign rbyte_wa = {rtail, RBW'(woff_ff)};
   assign dmeta_we = queue_msg && !cur_lane;
   assign rmeta_we = queue_msg && cur_lane;
   assign dmeta_wa = dtail;
   assign rmeta_wa = rtail;

   // Reads: head slot for receive, next candidate during poll.
   logic poll_rd;
   assign poll_rd  = (state_ff == S_PWAIT) || (state_ff == S_PCHK) ||
                     ((state_ff == S_IDLE) && start && req_action == lldq_pkg::ACT_POLL);
   assign dmeta_ra = poll_rd ? dpoll : dhead_ff;
   assign rmeta_ra = poll_rd ? rpoll : rhead_ff;
   assign dbyte_ra = {dhead_ff, DBW'(roff0_ff)};
   assign rbyte_ra = {rhead_ff, RBW'(roff1_ff)};

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = !busy;

   // Poll candidate checks for the current lane.
   logic p_more, p_due;
   assign p_more = plane_ff ? (rready_ff < rcount_ff) : (dready_ff < dcount_ff);
   assign p_due  = (plane_ff ? rmeta_rd[TW+SW-1:SW] : dmeta_rd[TW+SW-1:SW]) <= tick_ff;

   logic [SW-1:0] hsize;
   logic [7:0]    hbyte;
   assign hsize = lane_ff ? rmeta_rd[SW-1:0] : dmeta_rd[SW-1:0];
   assign hbyte = lane_ff ? rbyte_rd : dbyte_rd;

   always_ff @(posedge clock) begin
      strobe_ff <= 1'b0;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            lldq_pkg::REG_LATENCY: latency_ff <= csr_data;
            lldq_pkg::REG_DROP:    drop_n_ff  <= csr_data;
            lldq_pkg::REG_CONN:    conn_ff    <= csr_data[0];
            default: ;
         endcase
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               act_ff  <= req_action;
               lane_ff <= req_lane;
               len_ff  <= req_length;
               byte_ff <= req_data_byte;
               last_ff <= req_last;
               room_ff <= req_buffer_room;
               plane_ff <= 1'b0;
               if (req_action == lldq_pkg::ACT_TICK) begin
                  tick_ff <= req_tick_value;
               end
               state_ff <= (req_action == lldq_pkg::ACT_POLL) ? S_PWAIT : S_EXEC;
            end
         end
         S_PWAIT: state_ff <= S_PCHK;
         S_PCHK: begin
            // One slot is checked per visit; a hit re-reads the next slot.
            if (p_more && p_due) begin
               if (plane_ff) rready_ff <= rready_ff + 1'b1;
               else dready_ff <= dready_ff + 1'b1;
               state_ff <= S_PWAIT;
            end else if (!plane_ff) begin
               plane_ff <= 1'b1;
               state_ff <= S_PWAIT;
            end else begin
               state_ff <= S_DONE;
            end
         end
         S_DONE: begin
            strobe_ff <= 1'b1;
            status_ff <= lldq_pkg::ST_OK;
            dout_ff <= '0; lout_ff <= 1'b0; mlen_ff <= '0;
            state_ff <= S_IDLE;
         end
         S_EXEC: begin
            strobe_ff <= 1'b1;
            dout_ff <= '0; lout_ff <= 1'b0; mlen_ff <= '0;
            status_ff <= lldq_pkg::ST_OK;
            state_ff <= S_IDLE;
            case (act_ff)
               lldq_pkg::ACT_SEND: begin
                  if (first) begin
                     loss_ff <= v_loss;
                  end
                  if (last_ff) begin
                     if (queue_msg) begin
                        if (cur_lane) rcount_ff <= rcount_ff + 1'b1;
                        else dcount_ff <= dcount_ff + 1'b1;
                        status_ff <= lldq_pkg::ST_OK;
                     end else if (cur_verdict == lldq_pkg::ST_OK) begin
                        status_ff <= lldq_pkg::ST_FULL;
                     end else begin
                        status_ff <= cur_verdict;
                     end
                     woff_ff <= '0; verdict_ff <= '0; slen_ff <= '0;
                  end else begin
                     status_ff <= lldq_pkg::ST_CONT;
                     woff_ff <= woff_next;
                     slane_ff <= cur_lane;
                     verdict_ff <= cur_verdict;
                     slen_ff <= cur_len;
                  end
               end
               lldq_pkg::ACT_RECV: begin
                  if ((lane_ff ? rready_ff : dready_ff) == '0) begin
                     status_ff <= lldq_pkg::ST_NONE;
                  end else if (roff_sel == '0 && 16'(hsize) > room_ff) begin
                     status_ff <= lldq_pkg::ST_ROOM;
                     mlen_ff <= hsize;
                  end else begin
                     mlen_ff <= hsize;
                     if (roff_sel < hsize &&
                         roff_sel < (lane_ff ? RMaxC : DMaxC)) begin
                        dout_ff <= hbyte;
                     end
                     if (12'(roff_sel) + 12'd1 >= 12'(hsize)) begin
                        lout_ff <= 1'b1;
                        if (lane_ff) begin
                           rhead_ff <= rwrap((RCW+1)'(rhead_ff) + (RCW+1)'(1));
                           rcount_ff <= rcount_ff - 1'b1;
                           rready_ff <= rready_ff - 1'b1;
                           roff1_ff <= '0;
                        end else begin
                           dhead_ff <= dwrap((DCW+1)'(dhead_ff) + (DCW+1)'(1));
                           dcount_ff <= dcount_ff - 1'b1;
                           dready_ff <= dready_ff - 1'b1;
                           roff0_ff <= '0;
                        end
                     end else if (lane_ff) begin
                        roff1_ff <= roff1_ff + 1'b1;
                     end else begin
                        roff0_ff <= roff0_ff + 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         default: state_ff <= S_IDLE;
      endcase
      if (reset) begin
         state_ff <= S_IDLE; strobe_ff <= 1'b0;
         latency_ff <= '0; drop_n_ff <= '0; conn_ff <= 1'b0;
         tick_ff <= '0; loss_ff <= '0;
         dhead_ff <= '0; dcount_ff <= '0; dready_ff <= '0;
         rhead_ff <= '0; rcount_ff <= '0; rready_ff <= '0;
         woff_ff <= '0; slen_ff <= '0; verdict_ff <= '0; slane_ff <= 1'b0;
         roff0_ff <= '0; roff1_ff <= '0; plane_ff <= 1'b0;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_data_byte_out = dout_ff;
   assign rsp_last_out = lout_ff;
   assign rsp_message_length = mlen_ff;
   assign rsp_queued_datagrams = 5'(dcount_ff);
   assign rsp_queued_reliable = 5'(rcount_ff);
endmodule
`default_nettype wire

>>> rtl/core/lldq_checker.sv
// ----------------------------------------------------------------------------
// lldq_checker
// Port-level checks for the link delay queue.
// ----------------------------------------------------------------------------
`default_nettype none
module lldq_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_strobe,
   input wire logic [2:0] rsp_status,
   input wire logic       rsp_last_out,
   input wire logic [4:0] rsp_queued_datagrams,
   input wire logic [4:0] rsp_queued_reliable
);
   // Every accepted beat leads to busy on the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised");
   // A result closes the item.
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("busy after result");
   // Results are single-cycle.
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe) else $error("double result");
   // Last byte only on successful receive.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_out |-> rsp_status == lldq_pkg::ST_OK)
      else $error("bad last");
   // Counts stay in range.
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_queued_datagrams <= 5'd16 && rsp_queued_reliable <= 5'd16)
      else $error("count range");
endmodule

bind loopback_link_delay_queue lldq_checker u_lldq_checker (
   .clock, .reset, .start, .busy, .rsp_strobe, .rsp_status, .rsp_last_out,
   .rsp_queued_datagrams, .rsp_queued_reliable);
`default_nettype wire

>>> tb/tb_loopback_link_delay_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_loopback_link_delay_queue
// Self-checking bench for the two-lane link delay queue. A behavioral copy of
// the queue predicts the response to every accepted request beat; a monitor
// compares each response strobe against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_loopback_link_delay_queue;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  data;
      logic        last;
      logic [10:0] msg_len;
      logic [4:0]  n_dgram;
      logic [4:0]  n_rel;
   } link_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [1:0]  req_action = lldq_pkg::ACT_TICK;
   logic        req_lane = 1'b0;
   logic [47:0] req_tick_value = '0;
   logic [15:0] req_length = '0;
   logic [7:0]  req_data_byte = '0;
   logic        req_last = 1'b0;
   logic [15:0] req_buffer_room = '0;
   logic        csr_valid = 1'b0;
   logic [1:0]  csr_index = lldq_pkg::REG_LATENCY;
   logic [15:0] csr_data = '0;
   wire         busy, rsp_strobe, rsp_last_out, csr_ready;
   wire  [2:0]  rsp_status;
   wire  [7:0]  rsp_data_byte_out;
   wire  [10:0] rsp_message_length;
   wire  [4:0]  rsp_queued_datagrams, rsp_queued_reliable;

   loopback_link_delay_queue dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow state of the queue.
   logic [15:0] lat_cfg, drop_cfg;
   logic        conn_cfg;
   logic [47:0] now_tick;
   logic [15:0] loss_cnt;
   logic [47:0] due_tick [2][16];
   int          slot_size [2][16];
   bit   [7:0]  slot_bytes [2][16384];
   int          head_slot [2], held [2], due_cnt [2], rd_off [2];
   int          wr_off, snd_len;
   logic [2:0]  verdict;
   logic        snd_lane;

   link_rsp_type pending [$];
   int          n_errors = 0, n_checked = 0, n_beats = 0, n_delivered = 0;
   int          idle_cycles = 0;

   function automatic logic [2:0] open_verdict(logic ln, int len);
      int c;
      if (!conn_cfg) return lldq_pkg::ST_NOT_CONN;
      if (len > 1024) return lldq_pkg::ST_TOO_LONG;
      if (ln == 1'b0) begin
         c = loss_cnt + 1;
         if (drop_cfg != 0 && c >= drop_cfg) begin
            loss_cnt = '0;
            return lldq_pkg::ST_DROPPED;
         end
         loss_cnt = c[15:0];
      end
      if (held[ln] >= 16) return lldq_pkg::ST_FULL;
      return lldq_pkg::ST_OK;
   endfunction

   function automatic link_rsp_type link_response(logic [1:0] act, logic ln,
                                                  logic [47:0] tv, logic [15:0] len,
                                                  logic [7:0] db, logic lst,
                                                  logic [15:0] room);
      link_rsp_type r;
      int l, tail, h, sz, off;
      r = '0;
      case (act)
         lldq_pkg::ACT_TICK: now_tick = tv;
         lldq_pkg::ACT_POLL: begin
            for (l = 0; l < 2; l++)
               while (due_cnt[l] < held[l] &&
                      due_tick[l][(head_slot[l] + due_cnt[l]) % 16] <= now_tick)
                  due_cnt[l]++;
         end
         lldq_pkg::ACT_SEND: begin
            r.status = lldq_pkg::ST_CONT;
            if (wr_off == 0) begin
               snd_lane = ln;
               verdict = open_verdict(ln, len);
               snd_len = (verdict == lldq_pkg::ST_OK) ? len : 0;
            end
            l = snd_lane;
            tail = (head_slot[l] + held[l]) % 16;
            if (verdict == lldq_pkg::ST_OK && wr_off < snd_len && held[l] < 16)
               slot_bytes[l][tail * 1024 + wr_off] = db;
            if (wr_off < 2047) wr_off++;
            if (lst) begin
               if (verdict == lldq_pkg::ST_OK) begin
                  if (held[l] < 16) begin
                     due_tick[l][tail] = now_tick + lat_cfg;
                     slot_size[l][tail] = (snd_len < wr_off) ? snd_len : wr_off;
                     held[l]++;
                  end else begin
                     verdict = lldq_pkg::ST_FULL;
                  end
               end
               r.status = verdict;
               wr_off = 0;
               verdict = lldq_pkg::ST_OK;
               snd_len = 0;
            end
         end
         default: begin
            l = ln;
            if (due_cnt[l] == 0) begin
               r.status = lldq_pkg::ST_NONE;
            end else begin
               h = head_slot[l];
               sz = slot_size[l][h];
               off = rd_off[l];
               r.msg_len = sz[10:0];
               if (off == 0 && sz > room) begin
                  r.status = lldq_pkg::ST_ROOM;
               end else begin
                  r.status = lldq_pkg::ST_OK;
                  if (sz > 0 && off < sz) r.data = slot_bytes[l][h * 1024 + off];
                  if (off + 1 >= sz) begin
                     r.last = 1'b1;
                     head_slot[l] = (h + 1) % 16;
                     held[l]--;
                     due_cnt[l]--;
                     rd_off[l] = 0;
                  end else begin
                     rd_off[l] = off + 1;
                  end
               end
            end
         end
      endcase
      r.n_dgram = held[0][4:0];
      r.n_rel = held[1][4:0];
      return r;
   endfunction

   // Mostly back-to-back, sometimes a short pause, rarely a long one.
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 65) return 0;
      if (p < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(input logic [1:0] act, input logic ln, input logic [47:0] tv,
                            input logic [15:0] len, input logic [7:0] db, input logic lst,
                            input logic [15:0] room, output link_rsp_type r);
      int gap;
      start <= 1'b1;
      req_action <= act;
      req_lane <= ln;
      req_tick_value <= tv;
      req_length <= len;
      req_data_byte <= db;
      req_last <= lst;
      req_buffer_room <= room;
      do @(posedge clock); while (busy);
      r = link_response(act, ln, tv, len, db, lst, room);
      pending.push_back(r);
      n_beats++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      if (start) start <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         lldq_pkg::REG_LATENCY: lat_cfg = val;
         lldq_pkg::REG_DROP:    drop_cfg = val;
         default:               conn_cfg = val[0];
      endcase
   endtask

   task automatic set_link(input logic [15:0] lat, input logic [15:0] drop, input logic conn);
      csr_write(lldq_pkg::REG_LATENCY, lat);
      csr_write(lldq_pkg::REG_DROP, drop);
      csr_write(lldq_pkg::REG_CONN, {15'd0, conn});
   endtask

   // Sends one message of n beats; later beats carry random lane and length,
   // which the block must ignore.
   task automatic send_msg(input logic ln, input logic [15:0] len, input int n);
      link_rsp_type r;
      int i;
      for (i = 0; i < n; i++)
         send_beat(lldq_pkg::ACT_SEND, (i == 0) ? ln : 1'($urandom), 48'($urandom),
                   (i == 0) ? len : 16'($urandom), 8'($urandom), i == n - 1,
                   16'($urandom), r);
   endtask

   // Reads the head message of a lane until its last byte or a refusal.
   task automatic drain_msg(input logic ln, input logic [15:0] room);
      link_rsp_type r;
      do begin
         send_beat(lldq_pkg::ACT_RECV, ln, '0, '0, '0, 1'b0, room, r);
         if (r.status == lldq_pkg::ST_OK && r.last) n_delivered++;
      end while (r.status == lldq_pkg::ST_OK && !r.last);
   endtask

   task automatic test_directed();
      link_rsp_type r;
      int i;
      send_msg(1'b1, 16'd4, 2);                    // link down
      set_link(16'd5, 16'd3, 1'b1);
      send_msg(1'b1, 16'd1025, 1);                 // over the size limit
      send_msg(1'b1, 16'd0, 1);                    // zero-length message
      send_msg(1'b0, 16'd3, 3);
      send_msg(1'b0, 16'd2, 4);                    // extra bytes past the length
      send_msg(1'b0, 16'd1, 1);                    // third datagram: dropped
      send_msg(1'b1, 16'd1024, 2);                 // largest length, ended early
      // Nothing is ready yet.
      send_beat(lldq_pkg::ACT_RECV, 1'b0, '0, '0, '0, 1'b0, 16'hFFFF, r);
      send_beat(lldq_pkg::ACT_TICK, 1'b0, 48'd10, '0, '0, 1'b0, '0, r);
      send_beat(lldq_pkg::ACT_POLL, 1'b0, '0, '0, '0, 1'b0, '0, r);
      // Room too small, then a fitting receive.
      send_beat(lldq_pkg::ACT_RECV, 1'b0, '0, '0, '0, 1'b0, 16'd0, r);
      send_beat(lldq_pkg::ACT_RECV, 1'b0, '0, '0, '0, 1'b0, 16'd3, r);
      // Zero-length delivery.
      send_beat(lldq_pkg::ACT_RECV, 1'b1, '0, '0, '0, 1'b0, 16'd0, r);
      drain_msg(1'b0, 16'd3);
      drain_msg(1'b0, 16'hFFFF);
      drain_msg(1'b1, 16'hFFFF);
      // Ring full on the reliable lane, with the due tick wrapping past the top.
      set_link(16'hFFFF, 16'd0, 1'b1);
      send_beat(lldq_pkg::ACT_TICK, 1'b0, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, '0, r);
      for (i = 0; i < 17; i++) send_msg(1'b1, 16'd0, 1);
      send_beat(lldq_pkg::ACT_TICK, 1'b0, 48'h0, '0, '0, 1'b0, '0, r);
      send_beat(lldq_pkg::ACT_POLL, 1'b0, '0, '0, '0, 1'b0, '0, r);
      for (i = 0; i < 16; i++) drain_msg(1'b1, 16'd0);
   endtask

   task automatic test_random(input int n_items);
      link_rsp_type r;
      int first, p, len, n;
      logic ln;
      first = n_beats;
      while (n_beats - first < n_items) begin
         p = $urandom_range(0, 99);
         ln = 1'($urandom);
         if (p < 35) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1100)
                                              : $urandom_range(0, 8);
            n = (len == 0) ? 1 : len;
            if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 10);
            if (len > 40 && len <= 1024) n = $urandom_range(1, 40);
            send_msg(ln, len[15:0], n);
         end else if (p < 50) begin
            if ($urandom_range(0, 9) == 0)
               send_beat(lldq_pkg::ACT_TICK, 1'b0, {16'($urandom), 32'($urandom)},
                         '0, '0, 1'b0, '0, r);
            else
               send_beat(lldq_pkg::ACT_TICK, 1'b0,
                         now_tick + $urandom_range(0, 2 * lat_cfg + 4),
                         '0, '0, 1'b0, '0, r);
            send_beat(lldq_pkg::ACT_POLL, 1'b0, '0, '0, '0, 1'b0, '0, r);
         end else if (p < 80) begin
            drain_msg(ln, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'hFFFF);
         end else if (p < 90) begin
            send_msg(1'b0, 16'($urandom_range(1, 4)), $urandom_range(1, 4));
         end else begin
            send_beat(2'($urandom), ln, {16'($urandom), 32'($urandom)}, 16'($urandom),
                      8'($urandom), 1'($urandom), 16'($urandom), r);
         end
      end
      // Close any open message so the next register write sees an idle block.
      if (wr_off != 0) send_msg(1'b0, '0, 1);
   endtask

   always @(posedge clock) begin
      link_rsp_type got, want;
      if (rsp_strobe) begin
         got = '{rsp_status, rsp_data_byte_out, rsp_last_out, rsp_message_length,
                 rsp_queued_datagrams, rsp_queued_reliable};
         if (pending.size() == 0) begin
            $display("%0t: unexpected response, actual %h", $time, got);
            n_errors++;
         end else begin
            want = pending.pop_front();
            n_checked++;
            if (got.status !== want.status || got.data !== want.data ||
                got.last !== want.last || got.msg_len !== want.msg_len ||
                got.n_dgram !== want.n_dgram || got.n_rel !== want.n_rel) begin
               $display("%0t: mismatch, expected %h actual %h", $time, want, got);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: no beat in either direction for too long ends the run.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      lat_cfg = '0; drop_cfg = '0; conn_cfg = 1'b0;
      now_tick = '0; loss_cnt = '0;
      head_slot = '{0, 0}; held = '{0, 0}; due_cnt = '{0, 0}; rd_off = '{0, 0};
      wr_off = 0; snd_len = 0; verdict = lldq_pkg::ST_OK; snd_lane = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_link(16'd0, 16'd0, 1'b1);
      test_random(300);
      set_link(16'hFFFF, 16'hFFFF, 1'b1);
      test_random(250);
      set_link(16'($urandom_range(1, 20)), 16'd2, 1'b1);
      test_random(300);
      set_link(16'd3, 16'd1, 1'b1);
      test_random(200);
      csr_write(lldq_pkg::REG_CONN, 16'd0);
      test_random(100);
      set_link(16'($urandom_range(0, 8)), 16'($urandom_range(3, 6)), 1'b1);
      test_random(250);
      wait_idle();
      repeat (50) @(posedge clock);
      $display("Covered %0d request beats and %0d responses, %0d messages delivered,",
               n_beats, n_checked, n_delivered);
      $display("over six register settings with %0d failures.", n_errors);
      if (n_errors == 0 && pending.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end
endmodule

>>> sim.f
rtl/core/lldq_pkg.sv
rtl/core/lldq_ram.sv
rtl/core/loopback_link_delay_queue.sv
rtl/core/lldq_checker.sv
tb/tb_loopback_link_delay_queue.sv
